>>> hdl/smf_pkg.sv
// shared constants and command types for the sliding median filter
`default_nettype none

package smf_pkg;

    localparam int WINDOW_DEF = 8;
    localparam int DATA_W     = 16;

    typedef logic signed [DATA_W-1:0] sample_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr;     // store the accepted sample, advance write position
        logic step;   // one candidate/other compare at the issued indexes
        logic first;  // first compare of a candidate
        logic last;   // last compare of a candidate
        logic fin;    // load the median into the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_full;  // output register holds an untaken beat
        logic out_take;  // output beat taken this cycle
    } stat_t;

endpackage

`default_nettype wire

>>> hdl/smf_datapath.sv
// window store, rank counters and median output register
`default_nettype none

module smf_datapath #(
    parameter int WINDOW = smf_pkg::WINDOW_DEF,
    parameter int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire smf_pkg::cmd_t        cmd,
    input  wire logic [IDX_W-1:0]     cand_idx,
    input  wire logic [IDX_W-1:0]     other_idx,
    input  wire smf_pkg::sample_t     sample,
    output smf_pkg::stat_t            stat,
    output logic [15:0]               m_tdata,   // [15:0] median
    output logic                      m_tvalid,
    input  wire logic                 m_tready
);
    import smf_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] RANK_LO = CNT_W'((WINDOW - 1) / 2);
    localparam logic [CNT_W-1:0] RANK_HI = CNT_W'(WINDOW / 2);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    sample_t            mem [WINDOW];
    logic [WINDOW-1:0]  vld_reg;
    logic [IDX_W-1:0]   wpos_reg;
    sample_t            cand_reg, other_reg;
    logic               step_reg, first_reg, last_reg;
    logic [CNT_W-1:0]   lt_reg, le_reg;
    logic [CNT_W-1:0]   lt_next, le_next;
    sample_t            lo_reg, hi_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;
    logic signed [16:0] sum;

    // store write, entries never written read as zero through the valid bits
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wpos_reg] <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            wpos_reg <= '0;
        end
        else if (cmd.wr)
        begin
            vld_reg[wpos_reg] <= 1'b1;
            wpos_reg <= (wpos_reg == LAST_IDX) ? '0 : wpos_reg + 1'b1;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        cand_reg  <= vld_reg[cand_idx] ? mem[cand_idx] : '0;
        other_reg <= vld_reg[other_idx] ? mem[other_idx] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 1'b0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            step_reg  <= cmd.step;
            first_reg <= cmd.first;
            last_reg  <= cmd.last;
        end
    end

    always_comb
    begin
        lt_next = (first_reg ? '0 : lt_reg) + CNT_W'(other_reg < cand_reg);
        le_next = (first_reg ? '0 : le_reg) + CNT_W'(other_reg <= cand_reg);
    end

    always_ff @(posedge clk)
    begin
        if (step_reg)
        begin
            lt_reg <= lt_next;
            le_reg <= le_next;
            // candidate holds the wanted rank when lt <= r < le
            if (last_reg && lt_next <= RANK_LO && RANK_LO < le_next)
            begin
                lo_reg <= cand_reg;
            end
            if (last_reg && lt_next <= RANK_HI && RANK_HI < le_next)
            begin
                hi_reg <= cand_reg;
            end
        end
    end

    // floor of the mean, odd window has both ranks equal
    assign sum = {lo_reg[15], lo_reg} + {hi_reg[15], hi_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            out_data_reg <= sum[16:1];
        end
    end

    assign m_tdata       = out_data_reg;
    assign m_tvalid      = out_valid_reg;
    assign stat.out_full = out_valid_reg;
    assign stat.out_take = out_valid_reg && m_tready;

endmodule

`default_nettype wire

>>> hdl/smf_ctrl.sv
// controller sequencing the rank count over the window
`default_nettype none

module smf_ctrl #(
    parameter int WINDOW = smf_pkg::WINDOW_DEF,
    parameter int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire smf_pkg::stat_t    stat,
    output smf_pkg::cmd_t          cmd,
    output logic [IDX_W-1:0]       cand_idx,
    output logic [IDX_W-1:0]       other_idx
);
    import smf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             out_free;

    assign out_free = !stat.out_full || stat.out_take;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.wr     = 1'b1;
                    i_next     = '0;
                    k_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step  = 1'b1;
                cmd.first = (k_reg == '0);
                cmd.last  = (k_reg == LAST_IDX);
                if (k_reg == LAST_IDX)
                begin
                    k_next = '0;
                    if (i_reg == LAST_IDX)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
        end
    end

    assign cand_idx  = i_reg;
    assign other_idx = k_reg;

endmodule

`default_nettype wire

>>> hdl/sliding_median_filter_top.sv
// sliding window median filter: one sample in, median of the window out
// an accepted beat is stored, then every window entry is ranked against every entry in turn,
// one candidate/other compare at a time; after a drain state the median is loaded into the
// output register once it is free, and no new input beat is taken until that load is done
// the output register lets a new input beat be taken while a median waits
// reset: window entries read as zero, write position zero, no output pending
`default_nettype none

module sliding_median_filter_top #(
    parameter int WINDOW = smf_pkg::WINDOW_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic [15:0]      m_tdata,   // [15:0] median
    output logic             m_tvalid,
    input  wire logic        m_tready
);
    import smf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    cmd_t             cmd;
    stat_t            stat;
    logic [IDX_W-1:0] cand_idx;
    logic [IDX_W-1:0] other_idx;

    smf_ctrl #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .stat      (stat),
        .cmd       (cmd),
        .cand_idx  (cand_idx),
        .other_idx (other_idx)
    );

    smf_datapath #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cand_idx  (cand_idx),
        .other_idx (other_idx),
        .sample    (sample_t'(s_tdata)),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule

`default_nettype wire

>>> tb/sv/sliding_median_filter_top_tb.sv
// self-checking testbench for the sliding median filter: predicted medians vs output beats
`timescale 1ns / 100ps

module sliding_median_filter_top_tb;

    import smf_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int MAX_IDLE     = 10;
    localparam int RANDOM_ITEMS = 1375;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = WIN * WIN + 16;
    localparam int QUIET_LIMIT  = 5000;

    typedef struct {
        sample_t     sample;
        int unsigned idle;   // cycles the sender waits before offering this beat
        bit          drain;  // hold this beat back until every median has arrived
    } sample_item_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    sample_item_t pending_samples[$];
    sample_t      expected_medians[$];
    sample_t      window_copy[WIN];
    int unsigned  write_slot;
    int unsigned  idle_left;
    int unsigned  stall_left;
    int unsigned  stall_draw;
    int unsigned  hold_left;
    int unsigned  medians_seen;
    int unsigned  quiet_cycles;
    int unsigned  error_count;
    sample_t      want;

    sliding_median_filter_top #(
        .WINDOW(WIN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always #1 clk = ~clk;

    // store the sample in the ring, then take the median of the whole ring
    function automatic sample_t window_median(sample_t s);
        sample_t                 sorted[WIN];
        sample_t                 key;
        logic signed [DATA_W:0]  mid_sum;
        int                      j;
        window_copy[write_slot] = s;
        write_slot = (write_slot == WIN - 1) ? 0 : write_slot + 1;
        sorted = window_copy;
        for (int i = 1; i < WIN; i++)
        begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key)
            begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        if (WIN % 2 == 0)
        begin
            // 17-bit sum, dropping the low bit floors toward minus infinity
            mid_sum = sorted[WIN / 2 - 1] + sorted[WIN / 2];
            return mid_sum[DATA_W:1];
        end
        return sorted[WIN / 2];
    endfunction

    function automatic int unsigned draw_idle(int unsigned n);
        // every few hundred beats a stretch with no idling at all
        return (n % 300 < 50) ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic sample_t random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return sample_t'($urandom_range(0, 65535));
        if (pick < 17)
            return sample_t'($signed($urandom_range(0, 8)) - 4);  // near zero, many ties
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh7ffe;
            default: return 16'sh8001;
        endcase
    endfunction

    task automatic add_sample(sample_t s, bit drain);
        sample_item_t item;
        item.sample = s;
        item.idle   = draw_idle(pending_samples.size());
        item.drain  = drain;
        pending_samples.push_back(item);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            idle_left  <= 0;
            write_slot = 0;
            for (int k = 0; k < WIN; k++)
                window_copy[k] = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_medians.push_back(window_median(sample_t'(s_tdata)));
            if (!s_tvalid || s_tready)
            begin
                if (idle_left > 0)
                begin
                    idle_left <= idle_left - 1;
                    s_tvalid  <= 1'b0;
                end
                else if (pending_samples.size() > 0 &&
                         !(pending_samples[0].drain && expected_medians.size() > 0))
                begin
                    s_tdata   <= pending_samples[0].sample;
                    idle_left <= (pending_samples.size() > 1) ? pending_samples[1].idle : 0;
                    s_tvalid  <= 1'b1;
                    void'(pending_samples.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stall after each beat, two long hold-offs to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            medians_seen <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            medians_seen <= medians_seen + 1;
            if (medians_seen == 40 || medians_seen == 900)
            begin
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
            begin
                stall_draw = draw_idle(medians_seen);
                stall_left <= stall_draw;
                m_tready   <= (stall_draw == 0);
            end
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
        else
            m_tready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_medians.size() == 0)
            begin
                $display("%0t: median beat %0d with no sample outstanding",
                         $time, $signed(m_tdata));
                error_count++;
            end
            else
            begin
                want = expected_medians.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: median mismatch, expected %0d, got %0d",
                             $time, want, $signed(m_tdata));
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        error_count  = 0;
        quiet_cycles = 0;

        // window not yet filled: unwritten entries still count as zero
        add_sample(16'sd100, 1'b0);
        add_sample(-16'sd100, 1'b0);
        add_sample(16'sh7fff, 1'b0);
        add_sample(16'sh8000, 1'b0);
        add_sample(-16'sd1, 1'b0);
        add_sample(16'sd1, 1'b0);
        add_sample(16'sd3, 1'b0);
        // full window of the largest, then of the smallest value
        for (int i = 0; i < WIN; i++)
            add_sample(16'sh7fff, 1'b0);
        for (int i = 0; i < WIN; i++)
            add_sample(16'sh8000, 1'b0);
        // duplicates in the middle, negative odd sum that needs the extra bit
        add_sample(-16'sd3, 1'b0);
        add_sample(16'sd0, 1'b0);
        add_sample(-16'sd3, 1'b0);
        add_sample(16'sd0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_sample(random_sample(), (i == 0 || i == 700));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_samples.size() > 0 || s_tvalid || expected_medians.size() > 0);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
